[design/drt_pkg.sv]
// Shared types and constants for the divider and reload timer.
`default_nettype none
package drt_pkg;

    // Field widths
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned SEL_W      = 2;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned DIV_PRE_W  = 9;
    localparam int unsigned CNT_PRE_W  = 11;

    // Default divider period in ticks
    localparam int unsigned DIV_PERIOD_DEF = 256;

    // Control register
    localparam logic [DATA_W-1:0] CTRL_RESET      = 8'hF8;
    localparam int unsigned       CTRL_ENABLE_BIT = 2;

    // Counter period select codes in control bits 1:0
    localparam logic [1:0] PSEL_1024 = 2'd0;
    localparam logic [1:0] PSEL_16   = 2'd1;
    localparam logic [1:0] PSEL_64   = 2'd2;
    localparam logic [1:0] PSEL_256  = 2'd3;

    // Counter prescaler periods selected by control bits 1:0
    localparam logic [CNT_PRE_W-1:0] CNT_PERIOD_1024 = 11'd1024;
    localparam logic [CNT_PRE_W-1:0] CNT_PERIOD_16   = 11'd16;
    localparam logic [CNT_PRE_W-1:0] CNT_PERIOD_64   = 11'd64;
    localparam logic [CNT_PRE_W-1:0] CNT_PERIOD_256  = 11'd256;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } t_req_code;

    // Register select codes
    typedef enum logic [SEL_W-1:0] {
        SEL_DIV   = 2'd0,
        SEL_COUNT = 2'd1,
        SEL_MOD   = 2'd2,
        SEL_CTRL  = 2'd3
    } t_sel_code;

    // One request word as held in the input stage
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SEL_W-1:0]  reg_sel;
        logic [DATA_W-1:0] write_data;
    } t_req;

    // One result word
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              overflow;
    } t_rsp;

endpackage
`default_nettype wire

[design/drt_core.sv]
// Timer state registers and the single-pass update for one request word.
`default_nettype none
module drt_core #(
    parameter int unsigned DIV_PERIOD = drt_pkg::DIV_PERIOD_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_fire,
    input  wire drt_pkg::t_req i_req,
    output drt_pkg::t_rsp     o_rsp
);
    import drt_pkg::*;

    localparam logic [DIV_PRE_W-1:0] DivPeriod = DIV_PRE_W'(DIV_PERIOD);

    logic [DATA_W-1:0]    r_div,     n_div;
    logic [DIV_PRE_W-1:0] r_div_pre, n_div_pre;
    logic [DATA_W-1:0]    r_cnt,     n_cnt;
    logic [CNT_PRE_W-1:0] r_cnt_pre, n_cnt_pre;
    logic [DATA_W-1:0]    r_mod,     n_mod;
    logic [DATA_W-1:0]    r_ctrl,    n_ctrl;

    logic                 div_hit;
    logic                 cnt_hit;
    logic [CNT_PRE_W-1:0] cnt_period;
    logic [DATA_W-1:0]    cnt_step;

    // Select the counter prescaler period
    always_comb begin
        case (r_ctrl[1:0])
            PSEL_1024: cnt_period = CNT_PERIOD_1024;
            PSEL_16:   cnt_period = CNT_PERIOD_16;
            PSEL_64:   cnt_period = CNT_PERIOD_64;
            default:   cnt_period = CNT_PERIOD_256;
        endcase
    end

    assign div_hit  = (r_div_pre >= DivPeriod);
    assign cnt_hit  = (r_cnt_pre >= cnt_period);
    assign cnt_step = cnt_hit ? r_cnt + 8'd1 : r_cnt;

    // Work out next state and the result for the current word
    always_comb begin
        n_div         = r_div;
        n_div_pre     = r_div_pre;
        n_cnt         = r_cnt;
        n_cnt_pre     = r_cnt_pre;
        n_mod         = r_mod;
        n_ctrl        = r_ctrl;
        o_rsp         = '0;
        case (i_req.req_type)
            REQ_TICK: begin
                n_div     = div_hit ? r_div + 8'd1 : r_div;
                n_div_pre = (div_hit ? '0 : r_div_pre) + 9'd1;
                if (r_ctrl[CTRL_ENABLE_BIT]) begin
                    n_cnt_pre = (cnt_hit ? '0 : r_cnt_pre) + 11'd1;
                    if (cnt_step == '0) begin
                        n_cnt          = r_mod;
                        o_rsp.overflow = 1'b1;
                    end else begin
                        n_cnt = cnt_step;
                    end
                end
            end
            REQ_READ: begin
                case (i_req.reg_sel)
                    SEL_DIV:   o_rsp.read_data = r_div;
                    SEL_COUNT: o_rsp.read_data = r_cnt;
                    SEL_MOD:   o_rsp.read_data = r_mod;
                    default:   o_rsp.read_data = r_ctrl;
                endcase
            end
            REQ_WRITE: begin
                case (i_req.reg_sel)
                    SEL_DIV:   n_div  = '0;
                    SEL_COUNT: n_cnt  = i_req.write_data;
                    SEL_MOD:   n_mod  = i_req.write_data;
                    default:   n_ctrl = i_req.write_data;
                endcase
            end
            default: ;
        endcase
    end

    // Commit state when the word leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div     <= '0;
            r_div_pre <= '0;
            r_cnt     <= '0;
            r_cnt_pre <= '0;
            r_mod     <= '0;
            r_ctrl    <= CTRL_RESET;
        end else if (i_fire) begin
            r_div     <= n_div;
            r_div_pre <= n_div_pre;
            r_cnt     <= n_cnt;
            r_cnt_pre <= n_cnt_pre;
            r_mod     <= n_mod;
            r_ctrl    <= n_ctrl;
        end
    end

endmodule
`default_nettype wire

[design/divider_and_reload_timer_top.sv]
// Top level of the divider and reload timer: input stage, core and result stage.
`default_nettype none
// Takes one request word per clock while not stalled (tick, register read or
// register write) and returns one result word for each, in order. A word is
// held in the input register and applied to the timer state on its way to
// the result register, which offers it; sustained rate is one word per cycle
// while the output is not stalled, set by the single-pass update of the timer
// state. The input side stalls only while both stages are full and the
// result is held. DIV_PERIOD (1..511) sets how many ticks make one divider step.
module divider_and_reload_timer_top #(
    parameter int unsigned DIV_PERIOD = drt_pkg::DIV_PERIOD_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [drt_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [drt_pkg::SEL_W-1:0]  i_reg_sel,
    input  wire logic [drt_pkg::DATA_W-1:0] i_write_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [drt_pkg::DATA_W-1:0]      o_read_data,
    output logic                            o_overflow
);
    import drt_pkg::*;

    logic  r_in_valid;
    t_req  r_in;
    logic  r_out_valid;
    t_rsp  r_out;
    t_rsp  core_rsp;
    logic  in_take;
    logic  move;

    // Advance the input word when the result stage is free or draining
    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;
    assign in_take    = i_in_valid && !o_in_stall;

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= '{req_type: i_req_type, reg_sel: i_reg_sel, write_data: i_write_data};
        end
    end

    drt_core #(
        .DIV_PERIOD(DIV_PERIOD)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (move),
        .i_req  (r_in),
        .o_rsp  (core_rsp)
    );

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= core_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_overflow  = r_out.overflow;

    // Overflow is raised only by a tick
    a_ovf_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && core_rsp.overflow |-> r_in.req_type == REQ_TICK)
        else $error("overflow raised by a non-tick word");

    // A result word never carries both read data and overflow
    a_ovf_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overflow |-> r_out.read_data == '0)
        else $error("overflow with read data");

    // A result leaves only when the consumer takes it
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && !move |=> r_out_valid)
        else $error("result dropped while stalled");

    // Input stall only with a full input stage
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with room");

endmodule
`default_nettype wire

[tb/sv/divider_and_reload_timer_top_tb.sv]
// Self-checking testbench for the divider and reload timer top level.
`timescale 1ns / 1ps
module divider_and_reload_timer_top_tb;
    import drt_pkg::*;

    localparam int unsigned DIV_PERIOD   = DIV_PERIOD_DEF;
    localparam int unsigned N_RANDOM     = 750;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned IDLE_PCT     = 12;
    // Stretches with no idling: by sent word on the input, by cycle on the output
    localparam int unsigned IN_QUIET_LO  = 300;
    localparam int unsigned IN_QUIET_HI  = 450;
    localparam int unsigned OUT_QUIET_LO = 500;
    localparam int unsigned OUT_QUIET_HI = 700;

    // Request code that the block leaves unused
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [SEL_W-1:0]  sel;
        logic [DATA_W-1:0] data;
        bit                drain;
    } t_req_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [REQ_W-1:0]    i_req_type = '0;
    logic [SEL_W-1:0]    i_reg_sel = '0;
    logic [DATA_W-1:0]   i_write_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DATA_W-1:0]   o_read_data;
    logic                o_overflow;

    // Predicted timer state
    logic [DATA_W-1:0]    div_byte = '0;
    logic [DIV_PRE_W-1:0] div_pre = '0;
    logic [DATA_W-1:0]    cnt_byte = '0;
    logic [CNT_PRE_W-1:0] cnt_pre = '0;
    logic [DATA_W-1:0]    mod_byte = '0;
    logic [DATA_W-1:0]    ctrl_byte = CTRL_RESET;

    t_req_word req_queue[$];
    t_rsp      pending_rsp[$];
    t_req_word drv_word;
    bit        in_taken = 1'b0;

    int unsigned cycle_cnt = 0;
    int unsigned sent_cnt = 0;
    int unsigned gen_cnt = 0;
    int unsigned err_cnt = 0;
    int unsigned checked_cnt = 0;
    int unsigned tick_cnt = 0;
    int unsigned ovf_cnt = 0;
    int unsigned drain_cnt = 0;

    divider_and_reload_timer_top #(
        .DIV_PERIOD(DIV_PERIOD)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_reg_sel   (i_reg_sel),
        .i_write_data(i_write_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data),
        .o_overflow  (o_overflow)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request word to the predicted state and return its result word
    task automatic timer_step(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                              input logic [DATA_W-1:0] data, output t_rsp rsp);
        logic [CNT_PRE_W-1:0] period;
        rsp = '0;
        case (req)
            REQ_TICK: begin
                if (div_pre >= DIV_PERIOD) begin
                    div_byte = div_byte + 8'd1;
                    div_pre  = '0;
                end
                div_pre = div_pre + 9'd1;
                if (ctrl_byte[CTRL_ENABLE_BIT]) begin
                    case (ctrl_byte[1:0])
                        PSEL_1024: period = CNT_PERIOD_1024;
                        PSEL_16:   period = CNT_PERIOD_16;
                        PSEL_64:   period = CNT_PERIOD_64;
                        default:   period = CNT_PERIOD_256;
                    endcase
                    if (cnt_pre >= period) begin
                        cnt_byte = cnt_byte + 8'd1;
                        cnt_pre  = '0;
                    end
                    cnt_pre = cnt_pre + 11'd1;
                    // A zero counter reloads on every enabled tick
                    if (cnt_byte == '0) begin
                        cnt_byte     = mod_byte;
                        rsp.overflow = 1'b1;
                    end
                end
            end
            REQ_READ: begin
                case (sel)
                    SEL_DIV:   rsp.read_data = div_byte;
                    SEL_COUNT: rsp.read_data = cnt_byte;
                    SEL_MOD:   rsp.read_data = mod_byte;
                    default:   rsp.read_data = ctrl_byte;
                endcase
            end
            REQ_WRITE: begin
                case (sel)
                    SEL_DIV:   div_byte  = '0;
                    SEL_COUNT: cnt_byte  = data;
                    SEL_MOD:   mod_byte  = data;
                    default:   ctrl_byte = data;
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic push_word(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                             input logic [DATA_W-1:0] data, input bit drain);
        t_req_word w;
        w.req   = req;
        w.sel   = sel;
        w.data  = data;
        w.drain = drain;
        req_queue.push_back(w);
        if (req != REQ_UNUSED) gen_cnt++;
    endtask

    // Driver: present words at the falling edge, hold them while stalled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (req_queue.size() != 0
                        && (!req_queue[0].drain || pending_rsp.size() == 0)
                        && ((sent_cnt >= IN_QUIET_LO && sent_cnt < IN_QUIET_HI)
                            || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    drv_word = req_queue.pop_front();
                    if (drv_word.drain) drain_cnt++;
                    i_in_valid   <= 1'b1;
                    i_req_type   <= drv_word.req;
                    i_reg_sel    <= drv_word.sel;
                    i_write_data <= drv_word.data;
                    sent_cnt++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !(cycle_cnt >= OUT_QUIET_LO && cycle_cnt < OUT_QUIET_HI)
                           && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Monitor: check result words, then predict for an accepted request word
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.read_data = o_read_data;
                got.overflow  = o_overflow;
                if (pending_rsp.size() == 0) begin
                    $error("result word with none expected: read_data %0h overflow %0b",
                           got.read_data, got.overflow);
                    err_cnt++;
                end else begin
                    want = pending_rsp.pop_front();
                    checked_cnt++;
                    if (got.read_data !== want.read_data) begin
                        $error("read_data mismatch: expected %0h actual %0h",
                               want.read_data, got.read_data);
                        err_cnt++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow mismatch: expected %0b actual %0b",
                               want.overflow, got.overflow);
                        err_cnt++;
                    end
                end
            end
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                timer_step(i_req_type, i_reg_sel, i_write_data, want);
                if (i_req_type == REQ_TICK) tick_cnt++;
                if (want.overflow) ovf_cnt++;
                pending_rsp.push_back(want);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned kind;
        int unsigned burst;
        int unsigned pick;
        bit          long_done;
        logic [DATA_W-1:0] ctl;

        long_done = 1'b0;

        // Reset values, disabled tick, ignored fields, unused code
        push_word(REQ_READ, SEL_DIV, 8'h00, 1'b0);
        push_word(REQ_READ, SEL_COUNT, 8'h00, 1'b0);
        push_word(REQ_READ, SEL_MOD, 8'h00, 1'b0);
        push_word(REQ_READ, SEL_CTRL, 8'h00, 1'b0);
        push_word(REQ_TICK, SEL_CTRL, 8'hFF, 1'b0);
        push_word(REQ_UNUSED, SEL_CTRL, 8'hFF, 1'b0);
        // Zero counter reloads from modulo on the first enabled tick
        push_word(REQ_WRITE, SEL_MOD, 8'hFF, 1'b0);
        push_word(REQ_WRITE, SEL_COUNT, 8'h00, 1'b0);
        push_word(REQ_WRITE, SEL_CTRL, {5'b00000, 1'b1, PSEL_16}, 1'b0);
        push_word(REQ_TICK, SEL_DIV, 8'h00, 1'b0);
        push_word(REQ_READ, SEL_COUNT, 8'hFF, 1'b0);
        // Control keeps all eight bits
        push_word(REQ_WRITE, SEL_CTRL, 8'hFF, 1'b0);
        push_word(REQ_READ, SEL_CTRL, 8'h00, 1'b0);
        // Divider write clears regardless of data
        push_word(REQ_WRITE, SEL_DIV, 8'hAB, 1'b0);
        push_word(REQ_READ, SEL_DIV, 8'hFF, 1'b0);
        // Zero modulo flags overflow on every enabled tick
        push_word(REQ_WRITE, SEL_MOD, 8'h00, 1'b0);
        push_word(REQ_WRITE, SEL_COUNT, 8'h00, 1'b0);
        push_word(REQ_WRITE, SEL_CTRL, {5'b00000, 1'b1, PSEL_1024}, 1'b0);
        push_word(REQ_TICK, SEL_COUNT, 8'h55, 1'b0);
        push_word(REQ_TICK, SEL_MOD, 8'hAA, 1'b0);
        push_word(REQ_READ, SEL_COUNT, 8'h00, 1'b0);
        push_word(REQ_WRITE, SEL_CTRL, 8'h00, 1'b0);
        push_word(REQ_READ, SEL_CTRL, 8'h00, 1'b0);
        push_word(REQ_READ, SEL_MOD, 8'h00, 1'b0);

        // Random part; first word waits until all results are back
        push_word(REQ_READ, SEL_CTRL, 8'h00, 1'b1);
        gen_cnt = 0;
        while (gen_cnt < N_RANDOM) begin
            kind = $urandom_range(0, 9);
            if (!long_done && gen_cnt >= N_RANDOM / 2) begin
                // Long tick run to step the divider at least once
                long_done = 1'b1;
                repeat (DIV_PERIOD + 50) push_word(REQ_TICK, 2'($urandom), 8'($urandom), 1'b0);
                push_word(REQ_READ, SEL_DIV, 8'($urandom), 1'b0);
            end else if (kind == 0) begin
                // Noise, unused code included
                repeat ($urandom_range(1, 4))
                    push_word(2'($urandom), 2'($urandom), 8'($urandom), 1'b0);
            end else if (kind <= 7) begin
                // Preload near the top, enable, then a tick burst
                push_word(REQ_WRITE, SEL_MOD,
                          ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 1'b0);
                push_word(REQ_WRITE, SEL_COUNT,
                          ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
                ctl = 8'($urandom);
                if ($urandom_range(0, 5) != 0) ctl[CTRL_ENABLE_BIT] = 1'b1;
                push_word(REQ_WRITE, SEL_CTRL, ctl, 1'b0);
                burst = $urandom_range(4, 48);
                repeat (burst) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 15) begin
                        push_word(REQ_TICK, 2'($urandom), 8'($urandom), 1'b0);
                    end else if (pick < 19) begin
                        push_word(REQ_READ, 2'($urandom), 8'($urandom), 1'b0);
                    end else begin
                        // Period change in the middle of a burst
                        ctl = 8'($urandom);
                        ctl[CTRL_ENABLE_BIT] = 1'b1;
                        push_word(REQ_WRITE, SEL_CTRL, ctl, 1'b0);
                    end
                end
                push_word(REQ_READ, SEL_DIV, 8'($urandom), 1'b0);
                push_word(REQ_READ, SEL_COUNT, 8'($urandom), 1'b0);
                push_word(REQ_READ, SEL_MOD, 8'($urandom), 1'b0);
                push_word(REQ_READ, SEL_CTRL, 8'($urandom), 1'b0);
            end else if (kind == 8) begin
                push_word(REQ_WRITE, SEL_DIV, 8'($urandom), 1'b0);
                push_word(REQ_READ, SEL_DIV, 8'($urandom), 1'b0);
            end else begin
                // Register dump, sometimes after a full drain
                push_word(REQ_READ, SEL_DIV, 8'($urandom), $urandom_range(0, 2) == 0);
                push_word(REQ_READ, SEL_COUNT, 8'($urandom), 1'b0);
                push_word(REQ_READ, SEL_MOD, 8'($urandom), 1'b0);
                push_word(REQ_READ, SEL_CTRL, 8'($urandom), 1'b0);
            end
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then let the pipeline settle
        while (req_queue.size() != 0 || i_in_valid || pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            $error("%0d result words never arrived", pending_rsp.size());
            err_cnt++;
        end

        $display("checked %0d result words from %0d request words, %0d ticks",
                 checked_cnt, sent_cnt, tick_cnt);
        $display("counter reloads seen: %0d, full drains: %0d, errors: %0d",
                 ovf_cnt, drain_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
